/* design/chip8_pkg.sv */
// ----------------------------------------------------------------------------
// chip8_pkg
// Shared types, constants and helpers of the CHIP-8 core.
// ----------------------------------------------------------------------------
package chip8_pkg;

  localparam int MEM_BYTES_DEF   = 4096;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int SCREEN_W        = 64;
  localparam int SCREEN_H        = 32;
  localparam int ROW_AW          = $clog2(SCREEN_H);

  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam logic [15:0] SEED_RESET = 16'd44257;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;

  localparam logic REG_QUIRK = 1'b0;
  localparam logic REG_SEED  = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_EXEC = 2'd1,
    CMD_TICK = 2'd2,
    CMD_ROW  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADOP   = 2'd1,
    ST_KEYWAIT = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t        command;
    logic [11:0] address;
    logic [7:0]  data_byte;
    logic [15:0] keys_down;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [11:0] program_counter;
    logic        sound_on;
    logic        redraw;
    logic [63:0] row_pixels;
  } result_t;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_OR  = 3'd2,
    ALU_AND = 3'd3,
    ALU_XOR = 3'd4,
    ALU_SHR = 3'd5,
    ALU_SHL = 3'd6,
    ALU_EQ  = 3'd7
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [15:0] a;
    logic [15:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [15:0] res;
    logic        flag;
  } alu_rsp_t;

  // BCD digits {hundreds, tens, ones}; divisions by reciprocal multiply
  function automatic logic [11:0] bcd_digits(logic [7:0] v);
    logic [13:0] p100;
    logic [3:0]  h;
    logic [7:0]  r;
    logic [15:0] p10;
    logic [3:0]  t;
    logic [7:0]  o;
    p100 = 14'(v) * 14'd41;
    h    = 4'(p100[13:12]);
    r    = v - 8'(h * 8'd100);
    p10  = 16'(r) * 16'd205;
    t    = 4'(p10[15:11]);
    o    = r - 8'(t * 8'd10);
    return {h, t, o[3:0]};
  endfunction

endpackage

/* design/chip8_alu.sv */
// ----------------------------------------------------------------------------
// chip8_alu
// Shared arithmetic, logic, shift and compare unit.
// ----------------------------------------------------------------------------
module chip8_alu (
  input  chip8_pkg::alu_req_t req,
  output chip8_pkg::alu_rsp_t rsp
);

  logic [16:0] sum;

  assign sum = {1'b0, req.a} + {1'b0, req.b};

  always_comb begin
    rsp = '0;
    unique case (req.op)
      chip8_pkg::ALU_ADD: begin
        rsp.res  = sum[15:0];
        rsp.flag = sum[8];   // 8-bit carry
      end
      chip8_pkg::ALU_SUB: begin
        rsp.res  = req.a - req.b;
        rsp.flag = (req.a >= req.b);
      end
      chip8_pkg::ALU_OR:  rsp.res = req.a | req.b;
      chip8_pkg::ALU_AND: rsp.res = req.a & req.b;
      chip8_pkg::ALU_XOR: rsp.res = req.a ^ req.b;
      chip8_pkg::ALU_SHR: begin
        rsp.res  = {9'd0, req.b[7:1]};
        rsp.flag = req.b[0];
      end
      chip8_pkg::ALU_SHL: begin
        rsp.res  = {8'd0, req.b[6:0], 1'b0};
        rsp.flag = req.b[7];
      end
      chip8_pkg::ALU_EQ: rsp.flag = (req.a == req.b);
    endcase
  end

endmodule

/* design/chip8_ram.sv */
// ----------------------------------------------------------------------------
// chip8_ram
// Single-port byte RAM, registered read.
// ----------------------------------------------------------------------------
module chip8_ram #(
  parameter int DEPTH = chip8_pkg::MEM_BYTES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* design/chip8_scr.sv */
// ----------------------------------------------------------------------------
// chip8_scr
// Framebuffer row memory with per-row valid bits; invalid rows read as zero.
// ----------------------------------------------------------------------------
module chip8_scr (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clr,
  input  logic                         we,
  input  logic [chip8_pkg::ROW_AW-1:0] waddr,
  input  logic [chip8_pkg::SCREEN_W-1:0] wdata,
  input  logic [chip8_pkg::ROW_AW-1:0] raddr,
  output logic [chip8_pkg::SCREEN_W-1:0] rdata
);

  logic [chip8_pkg::SCREEN_W-1:0] mem [chip8_pkg::SCREEN_H];
  logic [chip8_pkg::SCREEN_H-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule

/* design/chip8_cpu_core.sv */
// ----------------------------------------------------------------------------
// chip8_cpu_core
// CHIP-8 processor core: RAM, framebuffer, registers, timers, sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears
// on result for one cycle with done high, and cannot be held off. Load and
// tick items finish straight from idle, a row read via S_ROW. An execute item
// steps through fetch, register read and execute (S_F1, S_F2, S_RX, S_RY,
// S_EX), then DXYN reads and writes each sprite row, FX33 writes each digit,
// FX55 stores and FX65 loads V0..VX, with an I update (S_IADV) in classic mode.
// The single RAM port and the one shared ALU set these steps; the sequencer
// steps them through fetch bytes, sprite rows and stored registers. No clearing
// pass: framebuffer rows carry valid bits, RAM and call stack start undefined.
// ----------------------------------------------------------------------------
module chip8_cpu_core #(
  parameter int MEM_BYTES   = chip8_pkg::MEM_BYTES_DEF,
  parameter int STACK_DEPTH = chip8_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  chip8_pkg::item_t   item,
  output logic               busy,
  output logic               done,
  output chip8_pkg::result_t result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int ROW_AW_L = chip8_pkg::ROW_AW;
  localparam logic REG_SEED_L = chip8_pkg::REG_SEED;

  // opcode families (top nibble)
  localparam logic [3:0] OPF_SYS  = 4'h0, OPF_JP  = 4'h1, OPF_CALL = 4'h2,
                         OPF_SE   = 4'h3, OPF_SNE = 4'h4, OPF_SER  = 4'h5,
                         OPF_LD   = 4'h6, OPF_ADD = 4'h7, OPF_ALU  = 4'h8,
                         OPF_SNER = 4'h9, OPF_LDI = 4'hA, OPF_JPV  = 4'hB,
                         OPF_RND  = 4'hC, OPF_DRW = 4'hD, OPF_SKP  = 4'hE,
                         OPF_MISC = 4'hF;
  localparam logic [15:0] OP_CLS = 16'h00E0, OP_RET = 16'h00EE;
  localparam logic [3:0] A8_MOV = 4'h0, A8_OR = 4'h1, A8_AND = 4'h2, A8_XOR = 4'h3,
                         A8_ADD = 4'h4, A8_SUB = 4'h5, A8_SHR = 4'h6, A8_SUBN = 4'h7,
                         A8_SHL = 4'hE;
  localparam logic [7:0] EX_SKP = 8'h9E, EX_SKNP = 8'hA1;
  localparam logic [7:0] FX_GDT = 8'h07, FX_KEY = 8'h0A, FX_SDT = 8'h15,
                         FX_SST = 8'h18, FX_ADDI = 8'h1E, FX_FONT = 8'h29,
                         FX_BCD = 8'h33, FX_STO = 8'h55, FX_LOD = 8'h65;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_ROW   = 14'b00000000000010,
    S_F1    = 14'b00000000000100,
    S_F2    = 14'b00000000001000,
    S_RX    = 14'b00000000010000,
    S_RY    = 14'b00000000100000,
    S_EX    = 14'b00000001000000,
    S_DR_RD = 14'b00000010000000,
    S_DR_WR = 14'b00000100000000,
    S_BCD   = 14'b00001000000000,
    S_ST    = 14'b00010000000000,
    S_LD_RD = 14'b00100000000000,
    S_LD_WR = 14'b01000000000000,
    S_IADV  = 14'b10000000000000
  } state_t;

  state_t state;

  // architectural state
  logic [7:0]  vregs [16];
  logic [11:0] cstack [STACK_DEPTH];
  logic [15:0] index_reg;
  logic [11:0] pc;
  logic [SP_W-1:0] sp;
  logic [7:0]  delay_count, sound_count;
  logic [15:0] key_latch, lfsr;
  logic        dirty;
  logic        quirk;
  logic [15:0] seed;

  // per-item working registers
  logic [7:0]  op_hi;
  logic [15:0] op;
  logic [7:0]  vx, vy;
  logic [15:0] keys_q;
  logic [3:0]  cnt;
  logic [ROW_AW_L-1:0] row_q;

  // result registers
  chip8_pkg::status_t status_q;
  logic        sound_q, redraw_q, rowcmd_q;
  logic [63:0] row_q_pix;

  logic        accept, cfg_wr;
  logic [3:0]  x, y, n;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [3:0]  reg_idx;
  logic [7:0]  reg_rd;
  logic [SP_W-1:0] sp_inc, sp_dec;
  logic [15:0] lfsr_nx;
  logic [15:0] latch_new, released;
  logic [11:0] digits;
  logic [7:0]  row_sum;
  logic [ROW_AW_L-1:0] row_sel;
  logic [63:0] spr;
  logic [127:0] spr_dbl;

  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]  ram_wd, ram_rd;
  logic        scr_clr, scr_we;
  logic [ROW_AW_L-1:0] scr_raddr;
  logic [63:0] scr_rd;
  chip8_pkg::alu_req_t alu_req;
  chip8_pkg::alu_rsp_t alu_rsp;

  function automatic logic [3:0] top_bit(logic [15:0] v);
    logic [3:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      if (v[i]) r = 4'(i);
    end
    return r;
  endfunction

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEED_L) ? {16'd0, seed} : {31'd0, quirk};

  assign x   = op[11:8];
  assign y   = op[7:4];
  assign n   = op[3:0];
  assign nn  = op[7:0];
  assign nnn = op[11:0];

  assign sp_inc = (sp == SP_W'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
  assign sp_dec = (sp == '0) ? SP_W'(STACK_DEPTH - 1) : sp - 1'b1;

  assign lfsr_nx   = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? chip8_pkg::LFSR_TAPS : 16'd0);
  assign latch_new = key_latch | keys_q;
  assign released  = latch_new & ~keys_q;
  assign digits    = chip8_pkg::bcd_digits(vx);

  // sprite row: byte at the left edge, rotated right by X (wraps)
  assign row_sum = vy + {4'd0, cnt};
  assign row_sel = row_sum[ROW_AW_L-1:0];
  assign spr_dbl = {ram_rd, 56'd0, ram_rd, 56'd0} >> vx[5:0];
  assign spr     = spr_dbl[63:0];

  // one register-file read port
  always_comb begin
    unique case (state)
      S_RX:    reg_idx = (op[15:12] == OPF_JPV && !quirk) ? 4'd0 : x;
      S_RY:    reg_idx = y;
      S_ST:    reg_idx = cnt;
      default: reg_idx = x;
    endcase
  end
  assign reg_rd = vregs[reg_idx];

  // shared ALU operand select
  always_comb begin
    alu_req = '{op: chip8_pkg::ALU_ADD, a: index_reg, b: {12'd0, cnt}};
    unique case (state)
      S_EX: begin
        unique case (op[15:12])
          OPF_SE, OPF_SNE: alu_req = '{chip8_pkg::ALU_EQ, {8'd0, vx}, {8'd0, nn}};
          OPF_SER, OPF_SNER: alu_req = '{chip8_pkg::ALU_EQ, {8'd0, vx}, {8'd0, vy}};
          OPF_ADD: alu_req = '{chip8_pkg::ALU_ADD, {8'd0, vx}, {8'd0, nn}};
          OPF_JPV: alu_req = '{chip8_pkg::ALU_ADD, {8'd0, vx}, {4'd0, nnn}};
          OPF_MISC: alu_req = '{chip8_pkg::ALU_ADD, index_reg, {8'd0, vx}};
          OPF_ALU: begin
            unique case (n)
              A8_MOV:  alu_req = '{chip8_pkg::ALU_OR,  16'd0,       {8'd0, vy}};
              A8_OR:   alu_req = '{chip8_pkg::ALU_OR,  {8'd0, vx}, {8'd0, vy}};
              A8_AND:  alu_req = '{chip8_pkg::ALU_AND, {8'd0, vx}, {8'd0, vy}};
              A8_XOR:  alu_req = '{chip8_pkg::ALU_XOR, {8'd0, vx}, {8'd0, vy}};
              A8_ADD:  alu_req = '{chip8_pkg::ALU_ADD, {8'd0, vx}, {8'd0, vy}};
              A8_SUB:  alu_req = '{chip8_pkg::ALU_SUB, {8'd0, vx}, {8'd0, vy}};
              A8_SUBN: alu_req = '{chip8_pkg::ALU_SUB, {8'd0, vy}, {8'd0, vx}};
              A8_SHR:  alu_req = '{chip8_pkg::ALU_SHR, 16'd0, {8'd0, quirk ? vx : vy}};
              A8_SHL:  alu_req = '{chip8_pkg::ALU_SHL, 16'd0, {8'd0, quirk ? vx : vy}};
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      S_IADV:  alu_req = '{chip8_pkg::ALU_ADD, index_reg, 16'(x) + 16'd1};
      default: ;   // I + cnt for RAM walks
    endcase
  end

  chip8_alu u_alu (.req(alu_req), .rsp(alu_rsp));

  // RAM port
  always_comb begin
    ram_we   = 1'b0;
    ram_wd   = item.data_byte;
    ram_addr = AW'(pc);
    unique case (state)
      S_IDLE: begin
        if (item.command == chip8_pkg::CMD_LOAD) begin
          ram_addr = AW'(item.address);
          ram_we   = accept;
        end
      end
      S_F1: ram_addr = AW'(pc + 12'd1);
      S_BCD: begin
        ram_addr = alu_rsp.res[AW-1:0];
        ram_we   = 1'b1;
        ram_wd   = (cnt == 4'd0) ? {4'd0, digits[11:8]} :
                   (cnt == 4'd1) ? {4'd0, digits[7:4]} : {4'd0, digits[3:0]};
      end
      S_ST: begin
        ram_addr = alu_rsp.res[AW-1:0];
        ram_we   = 1'b1;
        ram_wd   = reg_rd;
      end
      S_DR_RD, S_LD_RD: ram_addr = alu_rsp.res[AW-1:0];
      default: ;
    endcase
  end

  chip8_ram #(.DEPTH(MEM_BYTES), .AW(AW)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  assign scr_clr   = (state == S_EX) && (op == OP_CLS);
  assign scr_we    = (state == S_DR_WR);
  assign scr_raddr = (state == S_DR_RD) ? row_sel : item.address[ROW_AW_L-1:0];

  chip8_scr u_scr (
    .clk(clk), .rst(rst), .clr(scr_clr), .we(scr_we), .waddr(row_q),
    .wdata(scr_rd ^ spr), .raddr(scr_raddr), .rdata(scr_rd)
  );

  // call stack, no reset
  always_ff @(posedge clk) begin
    if (state == S_EX && op[15:12] == OPF_CALL) begin
      cstack[sp] <= pc;
    end
  end

  // unreset working registers
  always_ff @(posedge clk) begin
    if (accept) keys_q <= item.keys_down;
    if (state == S_F1) op_hi <= ram_rd;
    if (state == S_F2) op <= {op_hi, ram_rd};
    if (state == S_RX) vx <= reg_rd;
    if (state == S_RY) vy <= reg_rd;
    if (state == S_DR_RD) row_q <= row_sel;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      for (int i = 0; i < 16; i++) vregs[i] <= '0;
      index_reg   <= '0;
      pc          <= chip8_pkg::PC_RESET;
      sp          <= '0;
      delay_count <= '0;
      sound_count <= '0;
      key_latch   <= '0;
      lfsr        <= chip8_pkg::SEED_RESET;
      dirty       <= 1'b1;
      quirk       <= 1'b0;
      seed        <= chip8_pkg::SEED_RESET;
      cnt         <= '0;
      status_q    <= chip8_pkg::ST_OK;
      sound_q     <= 1'b0;
      redraw_q    <= 1'b0;
      rowcmd_q    <= 1'b0;
      row_q_pix   <= '0;
    end else begin
      done <= 1'b0;

      if (cfg_wr) begin
        if (paddr[2] == REG_SEED_L) begin
          seed <= pwdata[15:0];
          lfsr <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
        end else begin
          quirk <= pwdata[0];
        end
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            status_q  <= chip8_pkg::ST_OK;
            sound_q   <= 1'b0;
            rowcmd_q  <= 1'b0;
            row_q_pix <= '0;
            unique case (item.command)
              chip8_pkg::CMD_LOAD: done <= 1'b1;
              chip8_pkg::CMD_EXEC: state <= S_F1;
              chip8_pkg::CMD_TICK: begin
                if (delay_count != 8'd0) delay_count <= delay_count - 8'd1;
                if (sound_count != 8'd0) begin
                  sound_count <= sound_count - 8'd1;
                  sound_q     <= 1'b1;
                end
                done <= 1'b1;
              end
              chip8_pkg::CMD_ROW: state <= S_ROW;
            endcase
          end
        end

        S_ROW: begin
          row_q_pix <= scr_rd;
          redraw_q  <= dirty;
          rowcmd_q  <= 1'b1;
          dirty     <= 1'b0;
          done      <= 1'b1;
          state     <= S_IDLE;
        end

        S_F1: state <= S_F2;
        S_F2: begin
          pc    <= pc + 12'd2;
          state <= S_RX;
        end
        S_RX: state <= S_RY;
        S_RY: state <= S_EX;

        S_EX: begin
          done  <= 1'b1;
          state <= S_IDLE;
          unique case (op[15:12])
            OPF_SYS: begin
              if (op == OP_CLS) begin
                dirty <= 1'b1;
              end else if (op == OP_RET) begin
                sp <= sp_dec;
                pc <= cstack[sp_dec];
              end else begin
                status_q <= chip8_pkg::ST_BADOP;
              end
            end
            OPF_JP: pc <= nnn;
            OPF_CALL: begin
              sp <= sp_inc;
              pc <= nnn;
            end
            OPF_SE, OPF_SER: if (alu_rsp.flag) pc <= pc + 12'd2;
            OPF_SNE, OPF_SNER: if (!alu_rsp.flag) pc <= pc + 12'd2;
            OPF_LD:  vregs[x] <= nn;
            OPF_ADD: vregs[x] <= alu_rsp.res[7:0];
            OPF_ALU: begin
              unique case (n)
                A8_MOV, A8_OR, A8_AND, A8_XOR: begin
                  vregs[x]  <= alu_rsp.res[7:0];
                  vregs[15] <= 8'd0;
                end
                A8_ADD, A8_SUB, A8_SUBN, A8_SHR, A8_SHL: begin
                  vregs[x]  <= alu_rsp.res[7:0];
                  vregs[15] <= {7'd0, alu_rsp.flag};   // flag wins over VX
                end
                default: status_q <= chip8_pkg::ST_BADOP;
              endcase
            end
            OPF_LDI: index_reg <= {4'd0, nnn};
            OPF_JPV: pc <= alu_rsp.res[11:0];
            OPF_RND: begin
              lfsr     <= lfsr_nx;
              vregs[x] <= lfsr_nx[7:0] & nn;
            end
            OPF_DRW: begin
              vregs[15] <= 8'd0;
              cnt       <= '0;
              if (n != 4'd0) begin
                done  <= 1'b0;
                state <= S_DR_RD;
              end
            end
            OPF_SKP: begin
              if (nn == EX_SKP) begin
                if (keys_q[vx[3:0]]) pc <= pc + 12'd2;
              end else if (nn == EX_SKNP) begin
                if (!keys_q[vx[3:0]]) pc <= pc + 12'd2;
              end else begin
                status_q <= chip8_pkg::ST_BADOP;
              end
            end
            OPF_MISC: begin
              cnt <= '0;
              unique case (nn)
                FX_GDT: vregs[x] <= delay_count;
                FX_KEY: begin
                  // released latched keys all clear; the highest one is reported
                  key_latch <= latch_new & keys_q;
                  if (released != 16'd0) begin
                    vregs[x] <= {4'd0, top_bit(released)};
                  end else begin
                    pc       <= pc - 12'd2;
                    status_q <= chip8_pkg::ST_KEYWAIT;
                  end
                end
                FX_SDT:  delay_count <= vx;
                FX_SST:  sound_count <= vx;
                FX_ADDI: begin
                  index_reg <= alu_rsp.res;
                  vregs[15] <= {7'd0, |alu_rsp.res[15:12]};
                end
                FX_FONT: index_reg <= {10'd0, vx[3:0], 2'd0} + {12'd0, vx[3:0]};
                FX_BCD: begin
                  done  <= 1'b0;
                  state <= S_BCD;
                end
                FX_STO: begin
                  done  <= 1'b0;
                  state <= S_ST;
                end
                FX_LOD: begin
                  done  <= 1'b0;
                  state <= S_LD_RD;
                end
                default: status_q <= chip8_pkg::ST_BADOP;
              endcase
            end
          endcase
        end

        S_DR_RD: state <= S_DR_WR;
        S_DR_WR: begin
          if ((scr_rd & spr) != 64'd0) vregs[15] <= 8'd1;
          if (spr != 64'd0) dirty <= 1'b1;
          if (cnt + 4'd1 == n) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            cnt   <= cnt + 4'd1;
            state <= S_DR_RD;
          end
        end

        S_BCD: begin
          if (cnt == 4'd2) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end

        S_ST: begin
          if (cnt == x) begin
            if (quirk) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_IADV;
            end
          end else begin
            cnt <= cnt + 4'd1;
          end
        end

        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: begin
          vregs[cnt] <= ram_rd;
          if (cnt == x) begin
            if (quirk) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_IADV;
            end
          end else begin
            cnt   <= cnt + 4'd1;
            state <= S_LD_RD;
          end
        end

        S_IADV: begin
          index_reg <= alu_rsp.res;
          done      <= 1'b1;
          state     <= S_IDLE;
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // result bus: PC and dirty are live, stable while done is up
  assign result.status          = status_q;
  assign result.program_counter = pc;
  assign result.sound_on        = sound_q;
  assign result.redraw          = rowcmd_q ? redraw_q : dirty;
  assign result.row_pixels      = row_q_pix;

  // a result cycle never overlaps a busy sequencer
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // an accepted item either finishes at once or keeps the sequencer busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted item dropped");

  // execute step only after both operand reads
  a_ex_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_EX) |-> $past(state == S_RY))
    else $error("execute without operand read");

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CHIP-8 core. Every item that is accepted runs
// through an in-bench model of the core, and the model's result is queued.
// Each done strobe is checked field by field against the oldest queued result.
// Instructions are placed in RAM by load items just ahead of each execute, so
// no fetch, sprite read or block load ever touches RAM that was never written.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 64;     // margin for the longest execute to finish
  localparam int RANDOM_ITEMS = 1150;

  // register byte addresses on the config port
  localparam logic [2:0] ADDR_QUIRK = 3'd0;
  localparam logic [2:0] ADDR_SEED  = 3'd4;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  chip8_pkg::item_t   item = '0;
  logic        busy;
  logic        done;
  chip8_pkg::result_t result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  chip8_cpu_core u_top (
    .clk(clk), .rst(rst), .start(start), .item(item), .busy(busy),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // outputs move on the rising edge; sample them in the middle of the cycle
  logic busy_s = 1'b1;
  always @(negedge clk) busy_s <= busy;

  // -------------------------------------------------------------------------
  // core model state
  // -------------------------------------------------------------------------
  logic [7:0]  m_ram [4096];
  bit          m_ram_ok [4096];   // byte has been written at least once
  logic [63:0] m_scr [32];
  logic [7:0]  m_v [16];
  logic [15:0] m_i;
  logic [11:0] m_pc;
  logic [11:0] m_stk [16];
  bit          m_stk_ok [16];
  logic [3:0]  m_sp;
  logic [7:0]  m_dt, m_st;
  logic [15:0] m_latch, m_lfsr, m_seed;
  bit          m_dirty, m_quirk;

  chip8_pkg::result_t expected_q[$];
  int      errors = 0;
  int      sent = 0;
  int      idle_pct = 0;
  int      cyc = 0;

  function automatic void mem_store(logic [15:0] a, logic [7:0] d);
    m_ram[a[11:0]] = d;
    m_ram_ok[a[11:0]] = 1'b1;
  endfunction

  function automatic logic [11:0] pc_plus2(logic [11:0] p);
    return p + 12'd2;
  endfunction

  // one instruction at the current PC; returns its status
  function automatic chip8_pkg::status_t run_instr(logic [15:0] keys);
    logic [15:0] op;
    logic [3:0]  x, y, n;
    logic [7:0]  nn, t8;
    logic [11:0] nnn;
    logic [8:0]  sum;
    logic [63:0] spr;
    int          xs, ys, row;
    bit          f;
    op  = {m_ram[m_pc], m_ram[m_pc + 12'd1]};
    x   = op[11:8];
    y   = op[7:4];
    n   = op[3:0];
    nn  = op[7:0];
    nnn = op[11:0];
    m_pc = pc_plus2(m_pc);
    case (op[15:12])
      4'h0: begin
        if (op == 16'h00E0) begin
          for (int r = 0; r < 32; r++) m_scr[r] = '0;
          m_dirty = 1'b1;
        end else if (op == 16'h00EE) begin
          m_sp = m_sp - 4'd1;
          m_pc = m_stk[m_sp];
        end else return chip8_pkg::ST_BADOP;
      end
      4'h1: m_pc = nnn;
      4'h2: begin
        m_stk[m_sp] = m_pc;
        m_stk_ok[m_sp] = 1'b1;
        m_sp = m_sp + 4'd1;
        m_pc = nnn;
      end
      4'h3: if (m_v[x] == nn) m_pc = pc_plus2(m_pc);
      4'h4: if (m_v[x] != nn) m_pc = pc_plus2(m_pc);
      4'h5: if (m_v[x] == m_v[y]) m_pc = pc_plus2(m_pc);
      4'h6: m_v[x] = nn;
      4'h7: m_v[x] = m_v[x] + nn;
      4'h8: begin
        case (n)
          4'h0: begin m_v[x] = m_v[y]; m_v[15] = 8'd0; end
          4'h1: begin m_v[x] = m_v[x] | m_v[y]; m_v[15] = 8'd0; end
          4'h2: begin m_v[x] = m_v[x] & m_v[y]; m_v[15] = 8'd0; end
          4'h3: begin m_v[x] = m_v[x] ^ m_v[y]; m_v[15] = 8'd0; end
          4'h4: begin
            sum = {1'b0, m_v[x]} + {1'b0, m_v[y]};
            m_v[x] = sum[7:0];
            m_v[15] = {7'd0, sum[8]};
          end
          4'h5: begin
            f = m_v[x] >= m_v[y];
            m_v[x] = m_v[x] - m_v[y];
            m_v[15] = {7'd0, f};
          end
          4'h7: begin
            f = m_v[y] >= m_v[x];
            m_v[x] = m_v[y] - m_v[x];
            m_v[15] = {7'd0, f};
          end
          4'h6: begin
            t8 = m_quirk ? m_v[x] : m_v[y];
            m_v[x] = t8 >> 1;
            m_v[15] = {7'd0, t8[0]};
          end
          4'hE: begin
            t8 = m_quirk ? m_v[x] : m_v[y];
            m_v[x] = t8 << 1;
            m_v[15] = {7'd0, t8[7]};
          end
          default: return chip8_pkg::ST_BADOP;
        endcase
      end
      4'h9: if (m_v[x] != m_v[y]) m_pc = pc_plus2(m_pc);
      4'hA: m_i = {4'd0, nnn};
      4'hB: m_pc = (m_quirk ? {4'd0, m_v[x]} : {4'd0, m_v[0]}) + nnn;
      4'hC: begin
        f = m_lfsr[0];
        m_lfsr = m_lfsr >> 1;
        if (f) m_lfsr = m_lfsr ^ chip8_pkg::LFSR_TAPS;
        m_v[x] = m_lfsr[7:0] & nn;
      end
      4'hD: begin
        xs = m_v[x] % 64;
        ys = m_v[y] % 32;
        m_v[15] = 8'd0;
        for (int r = 0; r < n; r++) begin
          spr = {m_ram[12'(m_i + 16'(r))], 56'd0};
          row = (ys + r) % 32;
          if (xs != 0) spr = (spr >> xs) | (spr << (64 - xs));
          if ((m_scr[row] & spr) != 0) m_v[15] = 8'd1;
          if (spr != 0) m_dirty = 1'b1;
          m_scr[row] = m_scr[row] ^ spr;
        end
      end
      4'hE: begin
        f = keys[m_v[x][3:0]];
        if (nn == 8'h9E) begin
          if (f) m_pc = pc_plus2(m_pc);
        end else if (nn == 8'hA1) begin
          if (!f) m_pc = pc_plus2(m_pc);
        end else return chip8_pkg::ST_BADOP;
      end
      default: begin
        case (nn)
          8'h07: m_v[x] = m_dt;
          8'h0A: begin
            f = 1'b0;
            for (int k = 0; k < 16; k++) begin
              if (keys[k]) m_latch[k] = 1'b1;
              if (m_latch[k] && !keys[k]) begin
                m_v[x] = 8'(k);
                m_latch[k] = 1'b0;
                f = 1'b1;
              end
            end
            if (!f) begin
              m_pc = m_pc - 12'd2;
              return chip8_pkg::ST_KEYWAIT;
            end
          end
          8'h15: m_dt = m_v[x];
          8'h18: m_st = m_v[x];
          8'h1E: begin
            m_i = m_i + {8'd0, m_v[x]};
            m_v[15] = {7'd0, m_i > 16'h0FFF};
          end
          8'h29: m_i = {12'd0, m_v[x][3:0]} * 16'd5;
          8'h33: begin
            mem_store(m_i, m_v[x] / 8'd100);
            mem_store(m_i + 16'd1, (m_v[x] / 8'd10) % 8'd10);
            mem_store(m_i + 16'd2, m_v[x] % 8'd10);
          end
          8'h55: begin
            for (int k = 0; k <= x; k++) mem_store(m_i + 16'(k), m_v[k]);
            if (!m_quirk) m_i = m_i + {12'd0, x} + 16'd1;
          end
          8'h65: begin
            for (int k = 0; k <= x; k++) m_v[k] = m_ram[12'(m_i + 16'(k))];
            if (!m_quirk) m_i = m_i + {12'd0, x} + 16'd1;
          end
          default: return chip8_pkg::ST_BADOP;
        endcase
      end
    endcase
    return chip8_pkg::ST_OK;
  endfunction

  // model one accepted item and queue the result it must produce
  function automatic void predict_item(chip8_pkg::item_t it);
    chip8_pkg::result_t r;
    r = '0;
    r.status = chip8_pkg::ST_OK;
    case (it.command)
      chip8_pkg::CMD_LOAD: mem_store({4'd0, it.address}, it.data_byte);
      chip8_pkg::CMD_EXEC: r.status = run_instr(it.keys_down);
      chip8_pkg::CMD_TICK: begin
        if (m_dt != 0) m_dt = m_dt - 8'd1;
        if (m_st != 0) begin
          m_st = m_st - 8'd1;
          r.sound_on = 1'b1;
        end
      end
      default: ;
    endcase
    r.redraw = m_dirty;
    if (it.command == chip8_pkg::CMD_ROW) begin
      r.row_pixels = m_scr[it.address[4:0]];
      m_dirty = 1'b0;
    end
    r.program_counter = m_pc;
    expected_q.push_back(r);
  endfunction

  // -------------------------------------------------------------------------
  // result checker
  // -------------------------------------------------------------------------
  always @(negedge clk) begin
    chip8_pkg::result_t e;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, result.status);
          errors++;
        end
        if (result.program_counter !== e.program_counter) begin
          $error("program_counter exp %03h got %03h", e.program_counter,
                 result.program_counter);
          errors++;
        end
        if (result.sound_on !== e.sound_on) begin
          $error("sound_on exp %0b got %0b", e.sound_on, result.sound_on);
          errors++;
        end
        if (result.redraw !== e.redraw) begin
          $error("redraw exp %0b got %0b", e.redraw, result.redraw);
          errors++;
        end
        if (result.row_pixels !== e.row_pixels) begin
          $error("row_pixels exp %016h got %016h", e.row_pixels, result.row_pixels);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // driving tasks
  // -------------------------------------------------------------------------
  // hold start with the item until it is taken, then maybe go idle a while;
  // start is left high when no gap follows so back-to-back items stay packed
  task automatic send(chip8_pkg::cmd_t c, logic [11:0] a, logic [7:0] d,
                      logic [15:0] k);
    chip8_pkg::item_t it;
    it.command   = c;
    it.address   = a;
    it.data_byte = d;
    it.keys_down = k;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy_s);
    predict_item(it);
    sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_byte(logic [15:0] a, logic [7:0] d);
    send(chip8_pkg::CMD_LOAD, a[11:0], d, 16'($urandom));
  endtask

  // place op at PC, fill any unwritten bytes it reads, then execute it
  task automatic exec_op(logic [15:0] op, logic [15:0] keys);
    int cnt;
    cnt = 0;
    if (op == 16'h00EE && !m_stk_ok[m_sp - 4'd1]) op = 16'h00E0;
    if (op[15:12] == 4'hD) cnt = op[3:0];
    if (op[15:12] == 4'hF && op[7:0] == 8'h65) cnt = op[11:8] + 1;
    // data first: the opcode bytes must win if they overlap
    for (int r = 0; r < cnt; r++)
      if (!m_ram_ok[12'(m_i + 16'(r))]) load_byte(m_i + 16'(r), 8'($urandom));
    load_byte({4'd0, m_pc}, op[15:8]);
    load_byte({4'd0, m_pc + 12'd1}, op[7:0]);
    send(chip8_pkg::CMD_EXEC, 12'($urandom), 8'($urandom), keys);
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (a == ADDR_QUIRK) m_quirk = d[0];
    else begin
      m_seed = d[15:0];
      m_lfsr = (m_seed == 0) ? 16'd1 : m_seed;
    end
    @(posedge clk);
  endtask

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------
  task automatic test_alu();
    exec_op(16'h60FF, 16'h0000);
    exec_op(16'h6101, 16'hFFFF);
    exec_op(16'h8014, 16'h0000);   // carry out
    exec_op(16'h8015, 16'h0000);   // borrow
    exec_op(16'h8107, 16'h0000);
    exec_op(16'h8016, 16'h0000);   // shift right
    exec_op(16'h801E, 16'h0000);   // shift left
    exec_op(16'h8F14, 16'h0000);   // flag wins over VF result
    exec_op(16'h8013, 16'h0000);
    exec_op(16'h8008, 16'h0000);   // unknown ALU op
    exec_op(16'hC0FF, 16'h0000);
  endtask

  task automatic test_flow();
    exec_op(16'h2300, 16'h0000);   // call
    exec_op(16'h00EE, 16'h0000);   // return
    exec_op(16'h3000, 16'h0000);
    exec_op(16'h5010, 16'h0000);
    exec_op(16'hE09E, 16'h0001);
    exec_op(16'hE0FF, 16'h0000);   // unknown key op
    exec_op(16'h0123, 16'h0000);   // unknown system op
    exec_op(16'hB800, 16'h0000);
  endtask

  task automatic test_memory();
    exec_op(16'hAFFF, 16'h0000);
    exec_op(16'h60FF, 16'h0000);
    exec_op(16'hF01E, 16'h0000);   // I past 0x0FFF
    exec_op(16'hF033, 16'h0000);   // BCD with I past the top of RAM (wraps)
    exec_op(16'h613F, 16'h0000);
    exec_op(16'hD11F, 16'h0000);   // sprite wraps both edges
    send(chip8_pkg::CMD_ROW, 12'd31, 8'hFF, 16'hFFFF);
    send(chip8_pkg::CMD_ROW, 12'd45, 8'h00, 16'h0000);   // row number wraps
    exec_op(16'hFF55, 16'h0000);
    exec_op(16'hF265, 16'h0000);
    exec_op(16'hF00A, 16'h8001);   // keys held: wait
    exec_op(16'hF00A, 16'h0000);   // released: highest wins
    exec_op(16'hF018, 16'h0000);
    send(chip8_pkg::CMD_TICK, 12'hFFF, 8'h00, 16'h0000);
    exec_op(16'h00E0, 16'h0000);
    send(chip8_pkg::CMD_LOAD, 12'hFFF, 8'hFF, 16'h0000);
  endtask

  function automatic logic [15:0] random_op();
    logic [15:0] r;
    logic [7:0]  fx [10];
    fx = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65, 8'h00};
    r = 16'($urandom);
    case ($urandom_range(0, 17))
      0:  r = ($urandom_range(2) == 0) ? 16'h00E0 :
              ($urandom_range(1) == 0) ? 16'h00EE : {4'h0, r[11:0]};
      1:  r[15:12] = 4'h1;
      2:  r[15:12] = 4'h2;
      3:  r[15:12] = 4'h3;
      4:  r[15:12] = 4'h4;
      5:  r[15:12] = ($urandom_range(1) == 0) ? 4'h5 : 4'h9;
      6:  r[15:12] = 4'h6;
      7:  r[15:12] = 4'h7;
      8, 9: r[15:12] = 4'h8;
      10: r[15:12] = 4'hA;
      11: r[15:12] = 4'hB;
      12: r[15:12] = 4'hC;
      13: begin
        r[15:12] = 4'hD;
        if ($urandom_range(3) != 0) r[3:0] = 4'($urandom_range(0, 5));
      end
      14: begin
        r[15:12] = 4'hE;
        case ($urandom_range(2))
          0: r[7:0] = 8'h9E;
          1: r[7:0] = 8'hA1;
          default: ;
        endcase
      end
      default: begin
        r[15:12] = 4'hF;
        r[7:0] = fx[$urandom_range(0, 9)];
        if (r[7:0] == 8'h00) r[7:0] = 8'($urandom);
      end
    endcase
    return r;
  endfunction

  task automatic test_random(int pct, int count);
    int stop_at;
    logic [15:0] k;
    idle_pct = pct;
    stop_at = sent + count;
    while (sent < stop_at) begin
      k = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom);
      case ($urandom_range(0, 9))
        0: send(chip8_pkg::CMD_TICK, 12'($urandom), 8'($urandom), 16'($urandom));
        1: send(chip8_pkg::CMD_ROW, 12'($urandom), 8'($urandom), 16'($urandom));
        2: load_byte(16'($urandom), 8'($urandom));
        default: exec_op(random_op(), k);
      endcase
    end
    drain();
  endtask

  initial begin
    m_i = '0; m_pc = chip8_pkg::PC_RESET; m_sp = '0; m_dt = '0; m_st = '0;
    m_latch = '0; m_seed = chip8_pkg::SEED_RESET; m_lfsr = chip8_pkg::SEED_RESET;
    m_dirty = 1'b1; m_quirk = 1'b0;
    for (int a = 0; a < 4096; a++) begin m_ram[a] = '0; m_ram_ok[a] = 1'b0; end
    for (int a = 0; a < 32; a++) m_scr[a] = '0;
    for (int a = 0; a < 16; a++) begin
      m_v[a] = '0; m_stk[a] = '0; m_stk_ok[a] = 1'b0;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_alu();
    test_flow();
    test_memory();
    drain();   // hold off sending until everything has come back

    reg_write(ADDR_QUIRK, 32'd1);
    reg_write(ADDR_SEED, 32'd1);
    test_random(0, RANDOM_ITEMS / 4);
    reg_write(ADDR_QUIRK, 32'd0);
    reg_write(ADDR_SEED, 32'd65535);
    test_random(53, RANDOM_ITEMS / 4);
    reg_write(ADDR_QUIRK, 32'd1);
    reg_write(ADDR_SEED, 32'($urandom_range(1, 65535)));
    test_random(35, RANDOM_ITEMS / 4);
    reg_write(ADDR_QUIRK, 32'd0);
    test_random(53, RANDOM_ITEMS / 4);

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

/* files.f */
design/chip8_pkg.sv
design/chip8_alu.sv
design/chip8_ram.sv
design/chip8_scr.sv
design/chip8_cpu_core.sv
bench/tb_top.sv
